### sv/ptct_pkg.sv
package ptct_pkg;

  localparam int unsigned TableEntries = 256;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned PktW  = 32;
  localparam int unsigned ByteW = 48;
  localparam int unsigned LenW  = 16;
  localparam int unsigned SlotW = 8;
  localparam int unsigned UsedW = 9;

  typedef enum logic [1:0] {
    FN_SEND     = 2'd0,
    FN_RECV     = 2'd1,
    FN_READ     = 2'd2,
    FN_READ_ALT = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_READ_OK    = 3'd3,
    ST_READ_EMPTY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ
  } state_e;

  // counter word of one slot
  typedef struct packed {
    logic [ByteW-1:0] rx_bytes;
    logic [PktW-1:0]  rx_pkts;
    logic [ByteW-1:0] tx_bytes;
    logic [PktW-1:0]  tx_pkts;
  } ctr_t;

  typedef struct packed {
    logic            clear;  // fresh entry: start from zero
    logic            recv;   // receive direction
    logic [LenW-1:0] len;
  } acc_req_t;

endpackage

### sv/ptct_ram.sv
module ptct_ram #(
  parameter int unsigned Depth = ptct_pkg::TableEntries,
  parameter int unsigned Width = ptct_pkg::KeyW
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ptct_acc.sv
module ptct_acc (
  input  ptct_pkg::acc_req_t req_i,
  input  ptct_pkg::ctr_t     old_i,
  output ptct_pkg::ctr_t     new_o
);

  ptct_pkg::ctr_t                base;
  logic [ptct_pkg::PktW-1:0]     pkt_in;
  logic [ptct_pkg::PktW-1:0]     pkt_nx;
  logic [ptct_pkg::ByteW-1:0]    byte_in;
  logic [ptct_pkg::ByteW-1:0]    byte_nx;
  logic [ptct_pkg::ByteW:0]      sum;

  always_comb begin
    base    = req_i.clear ? '0 : old_i;
    pkt_in  = req_i.recv ? base.rx_pkts : base.tx_pkts;
    byte_in = req_i.recv ? base.rx_bytes : base.tx_bytes;
    // saturating increment and add
    pkt_nx  = (&pkt_in) ? pkt_in : pkt_in + 1'b1;
    sum     = {1'b0, byte_in} + (ptct_pkg::ByteW + 1)'(req_i.len);
    byte_nx = sum[ptct_pkg::ByteW] ? '1 : sum[ptct_pkg::ByteW-1:0];
    new_o   = base;
    if (req_i.recv) begin
      new_o.rx_pkts  = pkt_nx;
      new_o.rx_bytes = byte_nx;
    end else begin
      new_o.tx_pkts  = pkt_nx;
      new_o.tx_bytes = byte_nx;
    end
  end

endmodule

### sv/per_address_traffic_counter_table.sv
// Per-address traffic counter table.
// Slave stream (s_axis_*): one request per beat. tuser carries the function
// (send, receive, read slot); tdata carries address, packet length, slot.
// Master stream (m_axis_*): exactly one result per request. tuser carries the
// status; tdata carries key, the four saturating counters and entries used.
// Entries are allocated in slot order and never freed, so occupied slots are
// always 0 .. entries_used-1. An update scans the key memory one slot per
// cycle (one read port, registered read data) and stops at the first match.
// One request is in flight at a time; the next is accepted once the result
// has been loaded into the output register, so with a ready master side the
// scan length sets the request interval. Reset (rst_ni low, async) empties
// the table: entries_used returns to zero and no memory clearing pass is
// needed. If the master side stalls, the finished result is held in the
// output register and the block waits with its read data parked before
// committing the next result.
module per_address_traffic_counter_table #(
  parameter int unsigned TableEntries = ptct_pkg::TableEntries
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // ip_address[31:0], packet_length[47:32], slot_index[55:48]
  input  logic [1:0]   s_axis_tuser,  // func[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [207:0] m_axis_tdata,  // key_out[31:0], sent_packets[63:32],
                                      // sent_bytes[111:64], received_packets[143:112],
                                      // received_bytes[191:144], entries_used[200:192],
                                      // zero pad[207:201]
  output logic [2:0]   m_axis_tuser   // status[2:0]
);

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned CtrW = $bits(ptct_pkg::ctr_t);

  ptct_pkg::state_e state_q, state_d;
  ptct_pkg::func_e  func_q, func_d;
  logic [ptct_pkg::KeyW-1:0] addr_q, addr_d;
  logic [ptct_pkg::LenW-1:0] len_q, len_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] used_q, used_d;
  logic [IdxW-1:0] pslot_q, pslot_d;
  logic            pend_q, pend_d;
  logic            rd_ok_q, rd_ok_d;

  // output register
  logic                       m_valid_q;
  ptct_pkg::status_e          out_status_q, out_status_d;
  logic [ptct_pkg::KeyW-1:0]  out_key_q, out_key_d;
  ptct_pkg::ctr_t             out_ctr_q, out_ctr_d;
  logic [ptct_pkg::UsedW-1:0] out_used_q, out_used_d;
  logic                       out_load;

  // memory ports
  logic                      key_we, ctr_we, mem_re;
  logic [IdxW-1:0]           waddr, raddr;
  logic [ptct_pkg::KeyW-1:0] key_rd;
  ptct_pkg::ctr_t            ctr_rd;
  logic [CtrW-1:0]           ctr_rd_raw;

  ptct_pkg::acc_req_t acc_req;
  ptct_pkg::ctr_t     acc_new;

  logic                       in_acc, out_free, is_read, hit;
  logic [31:0]                idx32, used32, used_nx32;
  ptct_pkg::func_e            in_func;
  logic [ptct_pkg::KeyW-1:0]  in_addr;
  logic [ptct_pkg::LenW-1:0]  in_len;
  logic [ptct_pkg::SlotW-1:0] in_slot;

  assign in_func = ptct_pkg::func_e'(s_axis_tuser);
  assign in_addr = s_axis_tdata[31:0];
  assign in_len  = s_axis_tdata[47:32];
  assign in_slot = s_axis_tdata[55:48];

  assign s_axis_tready = (state_q == ptct_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign is_read       = (in_func == ptct_pkg::FN_READ) || (in_func == ptct_pkg::FN_READ_ALT);
  assign idx32         = 32'(in_slot);
  assign used32        = 32'(used_q);
  assign used_nx32     = used32 + 32'd1;
  assign hit           = pend_q && (key_rd == addr_q);

  ptct_ram #(
    .Depth (TableEntries),
    .Width (ptct_pkg::KeyW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (addr_q),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (key_rd)
  );

  ptct_ram #(
    .Depth (TableEntries),
    .Width (CtrW)
  ) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ctr_we),
    .waddr_i (waddr),
    .wdata_i (acc_new),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (ctr_rd_raw)
  );

  assign ctr_rd = ptct_pkg::ctr_t'(ctr_rd_raw);

  ptct_acc u_acc (
    .req_i (acc_req),
    .old_i (ctr_rd),
    .new_o (acc_new)
  );

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    addr_d       = addr_q;
    len_d        = len_q;
    ptr_d        = ptr_q;
    used_d       = used_q;
    pslot_d      = pslot_q;
    pend_d       = pend_q;
    rd_ok_d      = rd_ok_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_ctr_d    = out_ctr_q;
    out_used_d   = out_used_q;
    key_we       = 1'b0;
    ctr_we       = 1'b0;
    mem_re       = 1'b0;
    waddr        = pslot_q;
    raddr        = ptr_q[IdxW-1:0];
    acc_req.clear = 1'b0;
    acc_req.recv  = (func_q == ptct_pkg::FN_RECV);
    acc_req.len   = len_q;

    case (state_q)
      ptct_pkg::S_IDLE: begin
        if (in_acc) begin
          func_d = in_func;
          addr_d = in_addr;
          len_d  = in_len;
          if (is_read) begin
            // only occupied slots are fetched
            rd_ok_d = (idx32 < used32);
            mem_re  = (idx32 < used32);
            raddr   = idx32[IdxW-1:0];
            state_d = ptct_pkg::S_READ;
          end else begin
            ptr_d   = '0;
            pend_d  = 1'b0;
            state_d = ptct_pkg::S_SCAN;
          end
        end
      end

      ptct_pkg::S_READ: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = rd_ok_q ? ptct_pkg::ST_READ_OK : ptct_pkg::ST_READ_EMPTY;
          out_key_d    = rd_ok_q ? key_rd : '0;
          out_ctr_d    = rd_ok_q ? ctr_rd : '0;
          out_used_d   = used32[ptct_pkg::UsedW-1:0];
          state_d      = ptct_pkg::S_IDLE;
        end
      end

      ptct_pkg::S_SCAN: begin
        if (hit) begin
          if (out_free) begin
            ctr_we       = 1'b1;
            waddr        = pslot_q;
            out_load     = 1'b1;
            out_status_d = ptct_pkg::ST_UPDATED;
            out_key_d    = addr_q;
            out_ctr_d    = acc_new;
            out_used_d   = used32[ptct_pkg::UsedW-1:0];
            state_d      = ptct_pkg::S_IDLE;
          end
        end else if (ptr_q == used_q) begin
          // key absent from all occupied slots
          if (out_free) begin
            out_load  = 1'b1;
            out_key_d = addr_q;
            state_d   = ptct_pkg::S_IDLE;
            if (used32 == 32'(TableEntries)) begin
              out_status_d = ptct_pkg::ST_DROPPED;
              out_ctr_d    = '0;
              out_used_d   = used32[ptct_pkg::UsedW-1:0];
            end else begin
              acc_req.clear = 1'b1;
              key_we        = 1'b1;
              ctr_we        = 1'b1;
              waddr         = used_q[IdxW-1:0];
              used_d        = used_nx32[CntW-1:0];
              out_status_d  = ptct_pkg::ST_INSERTED;
              out_ctr_d     = acc_new;
              out_used_d    = used_nx32[ptct_pkg::UsedW-1:0];
            end
          end
        end else begin
          // fetch next slot
          mem_re  = 1'b1;
          raddr   = ptr_q[IdxW-1:0];
          pslot_d = ptr_q[IdxW-1:0];
          pend_d  = 1'b1;
          ptr_d   = ptr_q + 1'b1;
        end
      end

      default: begin
        state_d = ptct_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ptct_pkg::S_IDLE;
      used_q    <= '0;
      pend_q    <= 1'b0;
      ptr_q     <= '0;
      rd_ok_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      pend_q  <= pend_d;
      ptr_q   <= ptr_d;
      rd_ok_q <= rd_ok_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    addr_q       <= addr_d;
    len_q        <= len_d;
    pslot_q      <= pslot_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_ctr_q    <= out_ctr_d;
    out_used_q   <= out_used_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_used_q, out_ctr_q.rx_bytes, out_ctr_q.rx_pkts,
                          out_ctr_q.tx_bytes, out_ctr_q.tx_pkts, out_key_q};

endmodule
